[rtl/core/ttrj_pkg.sv]
// ----------------------------------------------------------------------------
// ttrj_pkg
// Shared types and constants for the ternary three-way residue join.
// ----------------------------------------------------------------------------
package ttrj_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int COUNT_W       = ADDR_W + 1;
    localparam int MAX_PER_QUERY = 64;
    localparam int QCNT_W        = $clog2(MAX_PER_QUERY + 1);
    localparam int WORD_W        = 64;
    localparam int MB_W          = 6;
    localparam int TR_W          = 58;
    localparam int CAP_W         = 25;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 58;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_ENTRY    = 2'd0,
        ST_NOMATCH  = 2'd1,
        ST_CAP      = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_MATCH_BITS = 2'd0,
        CFG_TARGET     = 2'd1,
        CFG_CAP        = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_REQ,
        S_BS_RD,
        S_BS_CMP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIN,
        S_FIN_CAP,
        S_CAP2,
        S_OVF,
        S_CONF
    } t_state;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    query_ld;
        logic    sab_calc;
        logic    req_calc;
        logic    bs_rd;
        logic    bs_upd;
        logic    scan_rd;
        logic    scan_adv;
        logic    push;
        logic    emit_pend;
        logic    emit_code;
        t_status code;
        logic    last;
        logic    finish;
        logic    finish_ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic conflict;
        logic bs_done;
        logic scan_end;
        logic res_eq;
        logic tern_ok;
        logic cnt_full;
        logic cap_hit;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/core/ttrj_ctrl.sv]
// ----------------------------------------------------------------------------
// ttrj_ctrl
// Sequencer: opcode decode, bisection and scan steps, result emission.
// ----------------------------------------------------------------------------
module ttrj_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_opcode,
    input  ttrj_pkg::t_dp_stat  i_stat,
    output logic                o_in_ready,
    output ttrj_pkg::t_dp_cmd   o_cmd
);

    ttrj_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttrj_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttrj_pkg::S_IDLE: begin
                if (i_in_valid && ttrj_pkg::t_opcode'(i_opcode) == ttrj_pkg::OP_QUERY)
                    n_state = ttrj_pkg::S_PREP;
            end
            ttrj_pkg::S_PREP:
                n_state = i_stat.conflict ? ttrj_pkg::S_CONF : ttrj_pkg::S_REQ;
            ttrj_pkg::S_REQ:    n_state = ttrj_pkg::S_BS_RD;
            ttrj_pkg::S_BS_RD:
                n_state = i_stat.bs_done ? ttrj_pkg::S_SCAN_RD : ttrj_pkg::S_BS_CMP;
            ttrj_pkg::S_BS_CMP: n_state = ttrj_pkg::S_BS_RD;
            ttrj_pkg::S_SCAN_RD:
                n_state = i_stat.scan_end ? ttrj_pkg::S_FIN : ttrj_pkg::S_SCAN_CHK;
            ttrj_pkg::S_SCAN_CHK: begin
                if (!i_stat.res_eq)
                    n_state = ttrj_pkg::S_FIN;
                else if (!i_stat.tern_ok)
                    n_state = ttrj_pkg::S_SCAN_RD;
                else if (i_stat.cnt_full)
                    n_state = ttrj_pkg::S_OVF;
                else if (i_stat.cap_hit)
                    n_state = ttrj_pkg::S_FIN_CAP;
                else if (!i_stat.pend_valid || i_stat.out_free)
                    n_state = ttrj_pkg::S_SCAN_RD;
            end
            ttrj_pkg::S_FIN: begin
                if (i_stat.out_free) n_state = ttrj_pkg::S_IDLE;
            end
            ttrj_pkg::S_FIN_CAP: begin
                if (i_stat.out_free)
                    n_state = i_stat.pend_valid ? ttrj_pkg::S_CAP2 : ttrj_pkg::S_IDLE;
            end
            ttrj_pkg::S_CAP2, ttrj_pkg::S_OVF, ttrj_pkg::S_CONF: begin
                if (i_stat.out_free) n_state = ttrj_pkg::S_IDLE;
            end
            default: n_state = ttrj_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = ttrj_pkg::ST_ENTRY;
        o_in_ready = 1'b0;
        unique case (r_state)
            ttrj_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (ttrj_pkg::t_opcode'(i_opcode))
                        ttrj_pkg::OP_CLEAR: o_cmd.clear    = 1'b1;
                        ttrj_pkg::OP_LOAD:  o_cmd.load     = 1'b1;
                        ttrj_pkg::OP_QUERY: o_cmd.query_ld = 1'b1;
                        default: ;
                    endcase
                end
            end
            ttrj_pkg::S_PREP:   o_cmd.sab_calc = 1'b1;
            ttrj_pkg::S_REQ:    o_cmd.req_calc = 1'b1;
            ttrj_pkg::S_BS_RD:  o_cmd.bs_rd    = !i_stat.bs_done;
            ttrj_pkg::S_BS_CMP: o_cmd.bs_upd   = 1'b1;
            ttrj_pkg::S_SCAN_RD: o_cmd.scan_rd = !i_stat.scan_end;
            ttrj_pkg::S_SCAN_CHK: begin
                if (i_stat.res_eq) begin
                    if (!i_stat.tern_ok) begin
                        o_cmd.scan_adv = 1'b1;
                    end else if (!i_stat.cnt_full && !i_stat.cap_hit &&
                                 (!i_stat.pend_valid || i_stat.out_free)) begin
                        o_cmd.push     = 1'b1;
                        o_cmd.scan_adv = 1'b1;
                    end
                end
            end
            ttrj_pkg::S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_pend = i_stat.pend_valid;
                    o_cmd.emit_code = !i_stat.pend_valid;
                    o_cmd.code      = ttrj_pkg::ST_NOMATCH;
                    o_cmd.last      = 1'b1;
                    o_cmd.finish    = 1'b1;
                end
            end
            ttrj_pkg::S_FIN_CAP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_pend = i_stat.pend_valid;
                    o_cmd.emit_code = !i_stat.pend_valid;
                    o_cmd.code      = ttrj_pkg::ST_CAP;
                    o_cmd.last      = !i_stat.pend_valid;
                    o_cmd.finish    = !i_stat.pend_valid;
                end
            end
            ttrj_pkg::S_CAP2: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_code = 1'b1;
                    o_cmd.code      = ttrj_pkg::ST_CAP;
                    o_cmd.last      = 1'b1;
                    o_cmd.finish    = 1'b1;
                end
            end
            ttrj_pkg::S_OVF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_code  = 1'b1;
                    o_cmd.code       = ttrj_pkg::ST_OVERFLOW;
                    o_cmd.last       = 1'b1;
                    o_cmd.finish_ovf = 1'b1;
                end
            end
            ttrj_pkg::S_CONF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_code = 1'b1;
                    o_cmd.code      = ttrj_pkg::ST_NOMATCH;
                    o_cmd.last      = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/ttrj_dp.sv]
// ----------------------------------------------------------------------------
// ttrj_dp
// Datapath: entry table, configuration, bisection bounds, ternary combine,
// pending entry and output register.
// ----------------------------------------------------------------------------
module ttrj_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ttrj_pkg::t_dp_cmd              i_cmd,
    input  logic                           i_cfg_we,
    input  logic [ttrj_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ttrj_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [63:0]                    i_a_pos_low,
    input  logic [63:0]                    i_a_pos_high,
    input  logic [63:0]                    i_a_neg_low,
    input  logic [63:0]                    i_a_neg_high,
    input  logic signed [63:0]             i_a_sum,
    input  logic [63:0]                    i_b_pos_low,
    input  logic [63:0]                    i_b_pos_high,
    input  logic [63:0]                    i_b_neg_low,
    input  logic [63:0]                    i_b_neg_high,
    input  logic signed [63:0]             i_b_sum,
    input  logic                           i_out_stall,
    output ttrj_pkg::t_dp_stat             o_stat,
    output logic                           o_out_valid,
    output logic [1:0]                     o_status,
    output logic [63:0]                    o_out_pos_low,
    output logic [63:0]                    o_out_pos_high,
    output logic [63:0]                    o_out_neg_low,
    output logic [63:0]                    o_out_neg_high,
    output logic signed [63:0]             o_out_sum,
    output logic                           o_last
);

    localparam int W = ttrj_pkg::WORD_W;
    localparam int ENT_W = 5 * W;

    logic [ENT_W-1:0] mem [ttrj_pkg::TABLE_DEPTH];

    logic [ttrj_pkg::MB_W-1:0]    r_match_bits;
    logic [ttrj_pkg::TR_W-1:0]    r_target;
    logic [ttrj_pkg::CAP_W-1:0]   r_cap;
    logic [ttrj_pkg::COUNT_W-1:0] r_count;
    logic [ttrj_pkg::CAP_W-1:0]   r_emitted;
    logic [ttrj_pkg::QCNT_W-1:0]  r_cnt;

    logic [2*W-1:0] r_a_p, r_a_n, r_b_p, r_b_n;
    logic [W-1:0]   r_a_s, r_b_s, r_sab, r_req;
    logic [ttrj_pkg::COUNT_W-1:0] r_lo, r_hi, r_mid;
    logic [ENT_W-1:0] r_rd;

    logic           r_pend_valid;
    logic [2*W-1:0] r_pend_p, r_pend_n;
    logic [W-1:0]   r_pend_s;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [63:0]        r_out_pos_low;
    logic [63:0]        r_out_pos_high;
    logic [63:0]        r_out_neg_low;
    logic [63:0]        r_out_neg_high;
    logic signed [63:0] r_out_sum;
    logic               r_last;

    logic [W-1:0]   rm, rd_res;
    logic [2*W-1:0] w_p, w_n, c_p, c_n;
    logic [2*W-1:0] both_p, both_n, one_p, one_n, none_v, bad;
    logic [W-1:0]   w_s;
    logic [ttrj_pkg::COUNT_W:0] mid_sum;
    logic [ttrj_pkg::CAP_W:0]   cap_sum;
    logic           out_free;

    assign rm      = (W'(1) << r_match_bits) - W'(1);
    assign w_s     = r_rd[W-1:0];
    assign w_n     = r_rd[3*W-1:W];
    assign w_p     = r_rd[5*W-1:3*W];
    assign rd_res  = w_s & rm;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign cap_sum = {1'b0, r_emitted} + (ttrj_pkg::CAP_W + 1)'(r_cnt);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        both_p = r_a_p & r_b_p;
        both_n = r_a_n & r_b_n;
        one_p  = (r_a_p | r_b_p) & ~(r_a_n | r_b_n);
        one_n  = (r_a_n | r_b_n) & ~(r_a_p | r_b_p);
        bad    = (both_p & ~w_n) | (both_n & ~w_p) | (one_p & w_p) | (one_n & w_n);
        none_v = ~(both_p | one_p | both_n | one_n);
        c_p    = (both_p & w_n) | (one_p & ~(w_p | w_n)) | (none_v & w_p);
        c_n    = (both_n & w_p) | (one_n & ~(w_p | w_n)) | (none_v & w_n);
    end

    always_comb begin
        o_stat.conflict   = |((r_a_p & r_b_p) & (r_a_n | r_b_n));
        o_stat.bs_done    = r_lo >= r_hi;
        o_stat.scan_end   = r_lo >= r_count;
        o_stat.res_eq     = rd_res == r_req;
        o_stat.tern_ok    = ~|bad;
        o_stat.cnt_full   = r_cnt == ttrj_pkg::QCNT_W'(ttrj_pkg::MAX_PER_QUERY);
        o_stat.cap_hit    = cap_sum >= {1'b0, r_cap};
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_bits <= ttrj_pkg::MB_W'(58);
            r_target     <= '0;
            r_cap        <= ttrj_pkg::CAP_W'(16777216);
        end else if (i_cfg_we) begin
            unique case (ttrj_pkg::t_cfg_idx'(i_cfg_index))
                ttrj_pkg::CFG_MATCH_BITS: r_match_bits <= i_cfg_data[ttrj_pkg::MB_W-1:0];
                ttrj_pkg::CFG_TARGET:     r_target     <= i_cfg_data[ttrj_pkg::TR_W-1:0];
                ttrj_pkg::CFG_CAP:        r_cap        <= i_cfg_data[ttrj_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < ttrj_pkg::COUNT_W'(ttrj_pkg::TABLE_DEPTH))
            mem[r_count[ttrj_pkg::ADDR_W-1:0]] <= {i_a_pos_high, i_a_pos_low,
                                                   i_a_neg_high, i_a_neg_low, i_a_sum};
        if (i_cmd.bs_rd)
            r_rd <= mem[mid_sum[ttrj_pkg::ADDR_W:1]];
        else if (i_cmd.scan_rd)
            r_rd <= mem[r_lo[ttrj_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_emitted <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count   <= '0;
                r_emitted <= '0;
            end else if (i_cmd.load && r_count < ttrj_pkg::COUNT_W'(ttrj_pkg::TABLE_DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.finish)
                r_emitted <= cap_sum[ttrj_pkg::CAP_W-1:0];
            else if (i_cmd.finish_ovf)
                r_emitted <= r_emitted + ttrj_pkg::CAP_W'(ttrj_pkg::MAX_PER_QUERY - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_ld) begin
            r_a_p <= {i_a_pos_high, i_a_pos_low};
            r_a_n <= {i_a_neg_high, i_a_neg_low};
            r_a_s <= i_a_sum;
            r_b_p <= {i_b_pos_high, i_b_pos_low};
            r_b_n <= {i_b_neg_high, i_b_neg_low};
            r_b_s <= i_b_sum;
        end
        if (i_cmd.sab_calc)
            r_sab <= r_a_s + r_b_s;
        if (i_cmd.req_calc)
            r_req <= ((W'(r_target) & rm) - (r_sab & rm)) & rm;
        if (i_cmd.bs_rd)
            r_mid <= mid_sum[ttrj_pkg::COUNT_W:1];
        if (i_cmd.push) begin
            r_pend_p <= c_p;
            r_pend_n <= c_n;
            r_pend_s <= r_sab + w_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo         <= '0;
            r_hi         <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.req_calc) begin
                r_lo <= '0;
                r_hi <= r_count;
            end else if (i_cmd.bs_upd) begin
                if (rd_res < r_req) r_lo <= r_mid + 1'b1;
                else                r_hi <= r_mid;
            end else if (i_cmd.scan_adv) begin
                r_lo <= r_lo + 1'b1;
            end
            if (i_cmd.query_ld) begin
                r_cnt        <= '0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.push) begin
                r_cnt        <= r_cnt + 1'b1;
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_code || i_cmd.emit_pend || (i_cmd.push && r_pend_valid)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pend || (i_cmd.push && r_pend_valid)) begin
            r_status       <= ttrj_pkg::ST_ENTRY;
            r_out_pos_low  <= r_pend_p[W-1:0];
            r_out_pos_high <= r_pend_p[2*W-1:W];
            r_out_neg_low  <= r_pend_n[W-1:0];
            r_out_neg_high <= r_pend_n[2*W-1:W];
            r_out_sum      <= r_pend_s;
            r_last         <= i_cmd.last;
        end else if (i_cmd.emit_code) begin
            r_status       <= i_cmd.code;
            r_out_pos_low  <= '0;
            r_out_pos_high <= '0;
            r_out_neg_low  <= '0;
            r_out_neg_high <= '0;
            r_out_sum      <= '0;
            r_last         <= i_cmd.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_pos_low  = r_out_pos_low;
    assign o_out_pos_high = r_out_pos_high;
    assign o_out_neg_low  = r_out_neg_low;
    assign o_out_neg_high = r_out_neg_high;
    assign o_out_sum      = r_out_sum;
    assign o_last         = r_last;

endmodule

[rtl/core/ternary_three_way_residue_join.sv]
// ----------------------------------------------------------------------------
// ternary_three_way_residue_join
// Three-way join of ternary vectors on a sorted residue table.
// ----------------------------------------------------------------------------
// One transaction at a time. Clear and load finish in the accept state. A
// query passes the accept state, the set-up states PREP and REQ, bisection
// steps of a read and a compare plus a closing check (up to 13 steps for a
// full table of 4096), then a read and a check per entry of the matching run
// and a closing state, all through the single read port of the table memory;
// results leave through a one-deep output register, and the scan waits while
// that register is stalled and an entry is already pending.
module ternary_three_way_residue_join (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [63:0]                     i_a_pos_low,
    input  logic [63:0]                     i_a_pos_high,
    input  logic [63:0]                     i_a_neg_low,
    input  logic [63:0]                     i_a_neg_high,
    input  logic signed [63:0]              i_a_sum,
    input  logic [63:0]                     i_b_pos_low,
    input  logic [63:0]                     i_b_pos_high,
    input  logic [63:0]                     i_b_neg_low,
    input  logic [63:0]                     i_b_neg_high,
    input  logic signed [63:0]              i_b_sum,
    input  logic                            i_cfg_we,
    input  logic [ttrj_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttrj_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [63:0]                     o_out_pos_low,
    output logic [63:0]                     o_out_pos_high,
    output logic [63:0]                     o_out_neg_low,
    output logic [63:0]                     o_out_neg_high,
    output logic signed [63:0]              o_out_sum,
    output logic                            o_last
);

    ttrj_pkg::t_dp_cmd  cmd;
    ttrj_pkg::t_dp_stat stat;
    logic               in_ready;

    assign o_in_stall = !in_ready;

    ttrj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ttrj_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_a_pos_low    (i_a_pos_low),
        .i_a_pos_high   (i_a_pos_high),
        .i_a_neg_low    (i_a_neg_low),
        .i_a_neg_high   (i_a_neg_high),
        .i_a_sum        (i_a_sum),
        .i_b_pos_low    (i_b_pos_low),
        .i_b_pos_high   (i_b_pos_high),
        .i_b_neg_low    (i_b_neg_low),
        .i_b_neg_high   (i_b_neg_high),
        .i_b_sum        (i_b_sum),
        .i_out_stall    (i_out_stall),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_out_pos_low  (o_out_pos_low),
        .o_out_pos_high (o_out_pos_high),
        .o_out_neg_low  (o_out_neg_low),
        .o_out_neg_high (o_out_neg_high),
        .o_out_sum      (o_out_sum),
        .o_last         (o_last)
    );

endmodule

[tb/ttrj_join_scoreboard.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttrj_join_scoreboard
// Watches both channels and the register port of the residue join, keeps its
// own copy of the table and registers, predicts the results of each accepted
// transaction and compares every returned result field by field.
// ----------------------------------------------------------------------------
module ttrj_join_scoreboard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [1:0]                      i_opcode,
    input  logic [63:0]                     i_a_pos_low,
    input  logic [63:0]                     i_a_pos_high,
    input  logic [63:0]                     i_a_neg_low,
    input  logic [63:0]                     i_a_neg_high,
    input  logic [63:0]                     i_a_sum,
    input  logic [63:0]                     i_b_pos_low,
    input  logic [63:0]                     i_b_pos_high,
    input  logic [63:0]                     i_b_neg_low,
    input  logic [63:0]                     i_b_neg_high,
    input  logic [63:0]                     i_b_sum,
    input  logic                            i_cfg_we,
    input  logic [ttrj_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ttrj_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [1:0]                      i_status,
    input  logic [63:0]                     i_out_pos_low,
    input  logic [63:0]                     i_out_pos_high,
    input  logic [63:0]                     i_out_neg_low,
    input  logic [63:0]                     i_out_neg_high,
    input  logic [63:0]                     i_out_sum,
    input  logic                            i_last,
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic [63:0] pl;
        logic [63:0] ph;
        logic [63:0] nl;
        logic [63:0] nh;
        logic [63:0] s;
    } t_tvec;

    typedef struct packed {
        ttrj_pkg::t_status status;
        t_tvec             v;
        logic              last;
    } t_join_result;

    t_tvec           table_mem [ttrj_pkg::TABLE_DEPTH];
    int unsigned     entry_count;
    longint unsigned emitted_total;
    logic [ttrj_pkg::MB_W-1:0]  match_bits;
    logic [ttrj_pkg::TR_W-1:0]  target_res;
    logic [ttrj_pkg::CAP_W-1:0] out_cap;
    t_join_result    expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic logic ternary_half(input logic [63:0] up, un, vp, vn, wp, wn,
                                          output logic [63:0] op, on);
        logic [63:0] bp, bn, sp, sn, none;
        bp = up & vp;
        bn = un & vn;
        sp = (up | vp) & ~(un | vn);
        sn = (un | vn) & ~(up | vp);
        op = '0;
        on = '0;
        if (((bp & ~wn) | (bn & ~wp) | (sp & wp) | (sn & wn)) != 64'd0) return 1'b0;
        none = ~(bp | sp | bn | sn);
        op = (bp & wn) | (sp & ~(wp | wn)) | (none & wp);
        on = (bn & wp) | (sn & ~(wp | wn)) | (none & wn);
        return 1'b1;
    endfunction

    task automatic queue_result(input ttrj_pkg::t_status st, input t_tvec v,
                                input logic last);
        t_join_result r;
        r.status = st;
        r.v      = v;
        r.last   = last;
        expected_results = {expected_results, r};
    endtask

    task automatic predict_join(input logic [1:0] op, input t_tvec a, input t_tvec b);
        logic [63:0] rm, req;
        int unsigned lo, hi, mid, i;
        t_tvec       hits[$];
        t_tvec       w, c;
        logic        more, capped, ok_l, ok_h;
        int          k;
        more   = 1'b0;
        capped = 1'b0;
        case (ttrj_pkg::t_opcode'(op))
            ttrj_pkg::OP_CLEAR: begin
                entry_count   = 0;
                emitted_total = 0;
            end
            ttrj_pkg::OP_LOAD: begin
                if (entry_count < ttrj_pkg::TABLE_DEPTH) begin
                    table_mem[entry_count] = a;
                    entry_count++;
                end
            end
            ttrj_pkg::OP_QUERY: begin
                if ((((a.pl & b.pl) & (a.nl | b.nl)) | ((a.ph & b.ph) & (a.nh | b.nh)))
                        != 64'd0) begin
                    queue_result(ttrj_pkg::ST_NOMATCH, '0, 1'b1);
                end else begin
                    rm  = (64'd1 << match_bits) - 64'd1;
                    req = ((64'(target_res) & rm) - ((a.s + b.s) & rm)) & rm;
                    lo  = 0;
                    hi  = entry_count;
                    while (lo < hi) begin
                        mid = (lo + hi) >> 1;
                        if ((table_mem[mid].s & rm) < req) lo = mid + 1;
                        else hi = mid;
                    end
                    for (i = lo; i < entry_count && (table_mem[i].s & rm) == req; i++) begin
                        w    = table_mem[i];
                        ok_l = ternary_half(a.pl, a.nl, b.pl, b.nl, w.pl, w.nl, c.pl, c.nl);
                        ok_h = ternary_half(a.ph, a.nh, b.ph, b.nh, w.ph, w.nh, c.ph, c.nh);
                        if (!(ok_l && ok_h)) continue;
                        c.s = a.s + b.s + w.s;
                        if (hits.size() == ttrj_pkg::MAX_PER_QUERY) begin
                            more = 1'b1;
                            break;
                        end
                        if (emitted_total + hits.size() >= longint'(out_cap)) begin
                            capped = 1'b1;
                            break;
                        end
                        hits = {hits, c};
                    end
                    if (more) begin
                        for (k = 0; k < ttrj_pkg::MAX_PER_QUERY - 1; k++)
                            queue_result(ttrj_pkg::ST_ENTRY, hits[k], 1'b0);
                        queue_result(ttrj_pkg::ST_OVERFLOW, '0, 1'b1);
                        emitted_total += ttrj_pkg::MAX_PER_QUERY - 1;
                    end else if (hits.size() == 0) begin
                        queue_result(capped ? ttrj_pkg::ST_CAP : ttrj_pkg::ST_NOMATCH,
                                     '0, 1'b1);
                    end else begin
                        for (k = 0; k < hits.size(); k++)
                            queue_result(ttrj_pkg::ST_ENTRY, hits[k],
                                         !capped && k == hits.size() - 1);
                        if (capped) queue_result(ttrj_pkg::ST_CAP, '0, 1'b1);
                        emitted_total += hits.size();
                    end
                end
            end
            default: ;
        endcase
    endtask

    // handshakes are sampled mid-cycle, ahead of the edge that completes them
    always @(negedge i_clk) begin
        t_join_result want;
        t_tvec        a, b;
        if (!i_rst_n) begin
            entry_count   = 0;
            emitted_total = 0;
            match_bits    = 6'd58;
            target_res    = '0;
            out_cap       = 25'd16777216;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (ttrj_pkg::t_cfg_idx'(i_cfg_index))
                    ttrj_pkg::CFG_MATCH_BITS: match_bits = i_cfg_data[ttrj_pkg::MB_W-1:0];
                    ttrj_pkg::CFG_TARGET:     target_res = i_cfg_data[ttrj_pkg::TR_W-1:0];
                    ttrj_pkg::CFG_CAP:        out_cap    = i_cfg_data[ttrj_pkg::CAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                a = {i_a_pos_low, i_a_pos_high, i_a_neg_low, i_a_neg_high, i_a_sum};
                b = {i_b_pos_low, i_b_pos_high, i_b_neg_low, i_b_neg_high, i_b_sum};
                predict_join(i_opcode, a, b);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("[%0t] mismatch: result with none expected, status %0d",
                             $time, i_status);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_status != want.status)
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                    if (i_out_pos_low != want.v.pl)
                        report_mismatch("pos_low", i_out_pos_low, want.v.pl);
                    if (i_out_pos_high != want.v.ph)
                        report_mismatch("pos_high", i_out_pos_high, want.v.ph);
                    if (i_out_neg_low != want.v.nl)
                        report_mismatch("neg_low", i_out_neg_low, want.v.nl);
                    if (i_out_neg_high != want.v.nh)
                        report_mismatch("neg_high", i_out_neg_high, want.v.nh);
                    if (i_out_sum != want.v.s)
                        report_mismatch("sum", i_out_sum, want.v.s);
                    if (i_last != want.last)
                        report_mismatch("last", 64'(i_last), 64'(want.last));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/tb_ternary_three_way_residue_join.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ternary_three_way_residue_join
// Stimulus for the residue join: a directed opening (empty table, conflicts,
// ternary overflow, cap, per-query overflow), then random phases of register
// settings, mostly sorted table loads and mostly well-formed queries, with bursty
// input and patterned output stall. Checking is in the scoreboard.
// ----------------------------------------------------------------------------
module tb_ternary_three_way_residue_join;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 260;

    typedef struct packed {
        logic [63:0] pl;
        logic [63:0] ph;
        logic [63:0] nl;
        logic [63:0] nh;
        logic [63:0] s;
    } t_tvec;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            in_valid;
    logic                            o_in_stall;
    logic [1:0]                      opcode;
    t_tvec                           a_drv;
    t_tvec                           b_drv;
    logic                            cfg_we;
    logic [ttrj_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ttrj_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            o_out_valid;
    logic                            out_stall;
    logic [1:0]                      o_status;
    logic [63:0]                     o_out_pos_low;
    logic [63:0]                     o_out_pos_high;
    logic [63:0]                     o_out_neg_low;
    logic [63:0]                     o_out_neg_high;
    logic [63:0]                     o_out_sum;
    logic                            o_last;
    int                              fail_count;
    int                              pending;

    logic [63:0] loaded_sums[$];
    logic [63:0] cur_rm;
    logic [57:0] cur_target;
    int          burst_left;
    int          items_sent;
    int          idle_cycles;
    int          stall_mode;
    int          stall_timer;

    ternary_three_way_residue_join uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (opcode),
        .i_a_pos_low    (a_drv.pl),
        .i_a_pos_high   (a_drv.ph),
        .i_a_neg_low    (a_drv.nl),
        .i_a_neg_high   (a_drv.nh),
        .i_a_sum        (a_drv.s),
        .i_b_pos_low    (b_drv.pl),
        .i_b_pos_high   (b_drv.ph),
        .i_b_neg_low    (b_drv.nl),
        .i_b_neg_high   (b_drv.nh),
        .i_b_sum        (b_drv.s),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_status       (o_status),
        .o_out_pos_low  (o_out_pos_low),
        .o_out_pos_high (o_out_pos_high),
        .o_out_neg_low  (o_out_neg_low),
        .o_out_neg_high (o_out_neg_high),
        .o_out_sum      (o_out_sum),
        .o_last         (o_last)
    );

    ttrj_join_scoreboard u_scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (o_in_stall),
        .i_opcode       (opcode),
        .i_a_pos_low    (a_drv.pl),
        .i_a_pos_high   (a_drv.ph),
        .i_a_neg_low    (a_drv.nl),
        .i_a_neg_high   (a_drv.nh),
        .i_a_sum        (a_drv.s),
        .i_b_pos_low    (b_drv.pl),
        .i_b_pos_high   (b_drv.ph),
        .i_b_neg_low    (b_drv.nl),
        .i_b_neg_high   (b_drv.nh),
        .i_b_sum        (b_drv.s),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .i_status       (o_status),
        .i_out_pos_low  (o_out_pos_low),
        .i_out_pos_high (o_out_pos_high),
        .i_out_neg_low  (o_out_neg_low),
        .i_out_neg_high (o_out_neg_high),
        .i_out_sum      (o_out_sum),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver stall: free flow, random, or long blocks, re-chosen periodically
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall   <= 1'b0;
            stall_mode  <= 0;
            stall_timer <= 0;
        end else begin
            if (stall_timer == 0) begin
                stall_mode  <= $urandom_range(0, 3);
                stall_timer <= $urandom_range(20, 200);
            end else begin
                stall_timer <= stall_timer - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                2:       out_stall <= (stall_timer % 16) < 11;
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ternary_three_way_residue_join regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_tvec rand_vec();
        t_tvec v;
        v = {rand64(), rand64(), rand64(), rand64(), rand64()};
        return v;
    endfunction

    function automatic t_tvec sparse_vec(input int coords, input logic [63:0] sum);
        logic [127:0] p, n;
        int           idx;
        t_tvec        v;
        p = '0;
        n = '0;
        for (int k = 0; k < coords; k++) begin
            idx = $urandom_range(0, 127);
            if ($urandom_range(0, 1)) begin
                p[idx] = 1'b1;
                n[idx] = 1'b0;
            end else begin
                n[idx] = 1'b1;
                p[idx] = 1'b0;
            end
        end
        v.pl = p[63:0];
        v.ph = p[127:64];
        v.nl = n[63:0];
        v.nh = n[127:64];
        v.s  = sum;
        return v;
    endfunction

    // called at a rising edge; returns at the edge that completes the transaction
    task automatic send_item(input logic [1:0] op, input t_tvec a, input t_tvec b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        a_drv    <= a;
        b_drv    <= b;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        if (op != ttrj_pkg::OP_NONE) items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [5:0] mb, input logic [57:0] tr,
                              input logic [24:0] cap);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= ttrj_pkg::CFG_MATCH_BITS;
        cfg_data  <= ttrj_pkg::CFG_DATA_W'(mb);
        @(posedge i_clk);
        cfg_index <= ttrj_pkg::CFG_TARGET;
        cfg_data  <= tr;
        @(posedge i_clk);
        cfg_index <= ttrj_pkg::CFG_CAP;
        cfg_data  <= ttrj_pkg::CFG_DATA_W'(cap);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_rm     = (64'd1 << mb) - 64'd1;
        cur_target = tr;
    endtask

    task automatic clear_table();
        send_item(ttrj_pkg::OP_CLEAR, rand_vec(), rand_vec());
        loaded_sums.delete();
    endtask

    task automatic load_entry(input t_tvec w);
        send_item(ttrj_pkg::OP_LOAD, w, rand_vec());
        if (loaded_sums.size() < ttrj_pkg::TABLE_DEPTH) loaded_sums = {loaded_sums, w.s};
    endtask

    // pair whose residue completes the target against the chosen entry
    task automatic query_entry(input int j, input int coords);
        logic [63:0] as, bs;
        as = rand64();
        bs = 64'(cur_target) - as - loaded_sums[j] + (rand64() & ~cur_rm);
        send_item(ttrj_pkg::OP_QUERY, sparse_vec(coords, as), sparse_vec(coords, bs));
    endtask

    initial begin
        t_tvec       va;
        logic [5:0]  mb;
        logic [24:0] cap;
        logic [63:0] r;
        int          n, nq, sel, phase;
        logic        sorted;

        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        opcode     = ttrj_pkg::OP_CLEAR;
        a_drv      = '0;
        b_drv      = '0;
        cfg_we     = 1'b0;
        cfg_index  = ttrj_pkg::CFG_MATCH_BITS;
        cfg_data   = '0;
        burst_left = 0;
        items_sent = 0;
        idle_cycles = 0;
        cur_rm     = (64'd1 << 58) - 64'd1;
        cur_target = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table under reset settings
        send_item(ttrj_pkg::OP_QUERY, '0, '0);

        set_config(6'd4, 58'd5, 25'd16777216);
        clear_table();
        load_entry('{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'hFFFF_FFFF_FFFF_FFF0});
        load_entry('{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'h8000_0000_0000_0003});
        load_entry('{pl: 0, ph: 0, nl: 64'd1, nh: 0, s: 64'h7FFF_FFFF_FFFF_FFF3});
        load_entry('{pl: 0, ph: 0, nl: 0, nh: 64'h8000_0000_0000_0000, s: 64'd7});
        // conflicting pair
        send_item(ttrj_pkg::OP_QUERY, '{pl: 64'd1, ph: 0, nl: 0, nh: 0, s: 0},
                  '{pl: 64'd1, ph: 0, nl: 64'd1, nh: 0, s: 0});
        // required residue 3 with zero masks: two entries
        send_item(ttrj_pkg::OP_QUERY, '{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd1},
                  '{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd1});
        // both positive on coordinate 0: only the entry negative there completes it
        send_item(ttrj_pkg::OP_QUERY,
                  '{pl: 64'd1, ph: 0, nl: 0, nh: 0, s: 64'hFFFF_FFFF_FFFF_FFFF},
                  '{pl: 64'd1, ph: 0, nl: 0, nh: 0, s: 64'd3});
        // top coordinate, residue 7 entry
        send_item(ttrj_pkg::OP_QUERY,
                  '{pl: 0, ph: 64'h8000_0000_0000_0000, nl: 0, nh: 0, s: 64'd14},
                  '{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd0});
        send_item(ttrj_pkg::OP_NONE, rand_vec(), rand_vec());
        send_item(ttrj_pkg::OP_QUERY, rand_vec(), rand_vec());

        set_config(6'd4, 58'd5, 25'd1);
        send_item(ttrj_pkg::OP_QUERY, '{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd1},
                  '{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd1});
        send_item(ttrj_pkg::OP_QUERY, '{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd1},
                  '{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd1});
        set_config(6'd4, 58'd5, 25'd0);
        clear_table();
        load_entry('{pl: 0, ph: 0, nl: 0, nh: 0, s: 64'd5});
        send_item(ttrj_pkg::OP_QUERY, '0, '0);

        // per-query overflow
        set_config(6'd1, 58'd0, 25'd16777216);
        clear_table();
        for (int k = 0; k < 70; k++) load_entry(sparse_vec(0, rand64() & ~64'd1));
        send_item(ttrj_pkg::OP_QUERY, '0, '0);

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       mb = 6'd0;
                1:       mb = 6'd58;
                2:       mb = 6'd63;
                default: mb = 6'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 5))
                0:       cap = 25'd0;
                1:       cap = 25'($urandom_range(1, 20));
                2:       cap = 25'($urandom_range(0, 25'h1FF_FFFF));
                default: cap = 25'd16777216;
            endcase
            set_config(mb, 58'(rand64()), cap);
            clear_table();
            n      = $urandom_range(1, 40);
            sorted = $urandom_range(0, 9) != 0;
            r      = rand64() & (cur_rm >> 1) & 64'hFFFF;
            for (int k = 0; k < n; k++) begin
                load_entry(sparse_vec($urandom_range(0, 3),
                                      sorted ? ((rand64() & ~cur_rm) | r) : rand64()));
                if (cur_rm - r >= 64'd2) r += 64'($urandom_range(0, 2));
            end
            nq = $urandom_range(4, 14);
            for (int q = 0; q < nq; q++) begin
                if (phase == 2 && q == 1) wait_idle();
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    query_entry($urandom_range(0, loaded_sums.size() - 1),
                                $urandom_range(0, 3));
                end else if (sel == 7) begin
                    send_item(ttrj_pkg::OP_QUERY, rand_vec(), rand_vec());
                end else if (sel == 8) begin
                    va = rand_vec();
                    send_item($urandom_range(0, 1) ? ttrj_pkg::OP_NONE : ttrj_pkg::OP_QUERY,
                              va, rand_vec());
                end else begin
                    load_entry(sparse_vec($urandom_range(0, 3), rand64()));
                end
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ternary_three_way_residue_join regression: pass");
        else
            $display("ternary_three_way_residue_join regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ttrj_pkg.sv
rtl/core/ttrj_ctrl.sv
rtl/core/ttrj_dp.sv
rtl/core/ternary_three_way_residue_join.sv
tb/ttrj_join_scoreboard.sv
tb/tb_ternary_three_way_residue_join.sv
